// ----- hdl/roex_pkg.sv -----
// Shared definitions for the roex excitation pattern unit: operation codes,
// fixed-point constants, sequencer states and the ROM build helper.
// No dependencies.
package roex_pkg;

    localparam int MAX_CHANNELS_DEF    = 512;
    localparam int MAX_FILTERS_DEF     = 512;
    localparam int ROEX_TABLE_SIZE_DEF = 1024;

    localparam logic [9:0] CHANNEL_COUNT_RESET = 10'd512;

    localparam logic [1:0] OP_LOAD_FILTER  = 2'd0;
    localparam logic [1:0] OP_LOAD_CHANNEL = 2'd1;
    localparam logic [1:0] OP_COMPUTE      = 2'd2;

    // 10*log10(2) in Q16, applied to a Q16 log2 value.
    localparam logic [17:0]        DB_PER_OCTAVE = 18'd197283;
    localparam logic signed [25:0] LEVEL_OFFSET  = 26'sd3342336;
    localparam logic signed [25:0] LEVEL_EMPTY   = -26'sd9895936;
    localparam logic [28:0]        SLOPE_MIN     = 29'd6554;
    localparam logic [40:0]        PREFIX_MAX    = {41{1'b1}};

    // Quotient bits kept from p*|cf-fc| over fc; anything larger saturates the index.
    localparam int QUOT_W = 22;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD_WR,
        S_FILT_WAIT,
        S_CH_RD,
        S_CH_TEST,
        S_PF_FIRST,
        S_PF_END,
        S_NORM,
        S_LOG,
        S_DB,
        S_MAG,
        S_SLOPE,
        S_PROD,
        S_DIV_CHK,
        S_DIV,
        S_IDX,
        S_ACC,
        S_ADD,
        S_DONE
    } state_t;

    // (a*b) >> 62 for a, b up to 2^62; used only while building the ROM.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = {32'd0, a[31:0]};
        ah  = {32'd0, a[63:32]};
        bl  = {32'd0, b[31:0]};
        bh  = {32'd0, b[63:32]};
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
        lo  = {mid[31:0], ll[31:0]};
        hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
        return {hi[61:0], lo[63:62]};
    endfunction

endpackage

// ----- hdl/roex_excitation_pattern_unit.sv -----
// Roex excitation pattern unit: filter, channel and prefix-sum memories, a
// roex ROM and the per-channel sequencer (log, slope, divide, accumulate).
// Depends on roex_pkg.
//
// A filter load is a single write; a channel load is a read-modify-write of
// the prefix sum. A compute item walks the channels until one lies above
// three times center or the channel count is reached; below center the
// normalizer and the 16-step log2 squaring loop run on a nonzero window,
// and the serial 22-step divider runs unless the quotient saturates.
// One item is worked at a time; a finished result waits in the output register
// while the next item is taken. Reset clears control state and sets
// channel_count to 512; the memories are not cleared.
module roex_excitation_pattern_unit #(
    parameter int MAX_CHANNELS    = roex_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_FILTERS     = roex_pkg::MAX_FILTERS_DEF,
    parameter int ROEX_TABLE_SIZE = roex_pkg::ROEX_TABLE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [8:0]  item_index,
    input  logic [19:0] frequency,
    input  logic [31:0] channel_power,
    input  logic [8:0]  window_first,
    input  logic [9:0]  window_end,
    input  logic [15:0] upper_slope,
    input  logic [15:0] lower_slope,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  filter_number,
    output logic [47:0] excitation,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);
    import roex_pkg::*;

    localparam int CH_AW   = $clog2(MAX_CHANNELS);
    localparam int PS_AW   = $clog2(MAX_CHANNELS + 1);
    localparam int FL_AW   = $clog2(MAX_FILTERS);
    localparam int RM_AW   = $clog2(ROEX_TABLE_SIZE);
    localparam int FL_W    = 52;
    localparam int CH_W    = 52 + 2 * PS_AW;
    localparam int IDX_MUL = ROEX_TABLE_SIZE * 25;
    localparam logic [63:0] DEN = 64'(IDX_MUL);

    typedef logic [15:0] rom_t [ROEX_TABLE_SIZE];

    // Restoring long division, evaluated only while building the ROM.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo, rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic rom_t build_rom();
        rom_t        tbl;
        logic [63:0] t, e, r, r40, v40, q, k;
        int          i;
        t = 64'd1 << 62;
        e = 64'd1 << 62;
        r = 64'd1 << 62;
        for (k = 64'd1; k < 64'd64 && t != 64'd0; k = k + 64'd1)
        begin
            t = udiv64(t, DEN * k) * 64'd512;
            if (k[0])
            begin
                e = e - t;
            end
            else
            begin
                e = e + t;
            end
        end
        for (i = 0; i < ROEX_TABLE_SIZE; i++)
        begin
            if (i > 0)
            begin
                r = mul_q62(r, e);
            end
            r40 = r >> 22;
            v40 = r40 + udiv64(r40 * 64'(i) * 64'd512, DEN);
            q   = (v40 + (64'd1 << 23)) >> 24;
            tbl[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
        return tbl;
    endfunction

    localparam rom_t ROEX_ROM = build_rom();

    // Memories.
    logic [FL_W-1:0] filt_mem [MAX_FILTERS];
    logic [CH_W-1:0] ch_mem   [MAX_CHANNELS];
    logic [40:0]     ps_mem   [MAX_CHANNELS + 1];

    logic             filt_we;
    logic [FL_AW-1:0] filt_waddr, filt_raddr;
    logic [FL_W-1:0]  filt_wdata, filt_rd_reg;
    logic             ch_we;
    logic [CH_AW-1:0] ch_waddr, ch_raddr;
    logic [CH_W-1:0]  ch_wdata, ch_rd_reg;
    logic             ps_we;
    logic [PS_AW-1:0] ps_waddr, ps_raddr;
    logic [40:0]      ps_wdata, ps_rd_reg, ps_rd;
    logic             ps_zero_reg;
    logic [RM_AW-1:0] rom_addr;
    logic [15:0]      rom_rd_reg;

    // Control and datapath registers.
    state_t           state_reg, state_next;
    logic [9:0]       channel_count_reg;
    logic             out_valid_reg;
    logic [8:0]       filter_number_reg;
    logic [47:0]      excitation_reg;
    logic [8:0]       ix_reg;
    logic [19:0]      freq_reg;
    logic [31:0]      pow_reg;
    logic [PS_AW-1:0] wf_reg, we_reg;
    logic [19:0]      fc_reg;
    logic [23:0]      pu_reg;
    logic [15:0]      pl_reg;
    logic [PS_AW-1:0] j_reg;
    logic [47:0]      acc_reg;
    logic [40:0]      pf_reg;
    logic [40:0]      norm_reg;
    logic [5:0]       sh_reg;
    logic [30:0]      mant_reg;
    logic [15:0]      frac_reg;
    logic [3:0]       step_reg;
    logic [4:0]       div_cnt_reg;
    logic signed [25:0] lv_reg;
    logic [28:0]      mag2_reg;
    logic [28:0]      p_reg;
    logic [19:0]      dm_reg;
    logic [48:0]      num_reg;
    logic [19:0]      rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [47:0]      prod_reg;

    // Combinational helpers.
    logic             accept;
    logic             idx_ok_filter, idx_ok_channel;
    logic [PS_AW-1:0] n_clamp;
    logic [PS_AW-1:0] wf_clamp, we_clamp;
    logic [19:0]      ch_freq;
    logic [31:0]      ch_power;
    logic [PS_AW-1:0] ch_wf, ch_wend;
    logic [41:0]      ps_sum;
    logic [40:0]      win_sum;
    logic [61:0]      sq;
    logic [31:0]      sq_sh;
    logic [39:0]      db_full;
    logic signed [25:0] lv_calc;
    logic [24:0]      mag;
    logic [40:0]      m2_full;
    logic signed [30:0] sp;
    logic [20:0]      rem2;
    logic [39:0]      idx_full;
    logic [48:0]      acc_sum;
    logic             out_free;

    assign accept         = in_valid && (state_reg == S_IDLE);
    assign in_stall       = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign filter_number  = filter_number_reg;
    assign excitation     = excitation_reg;
    assign out_free       = !out_valid_reg || !out_stall;

    assign idx_ok_filter  = int'(item_index) < MAX_FILTERS;
    assign idx_ok_channel = int'(item_index) < MAX_CHANNELS;
    assign n_clamp  = (int'(channel_count_reg) > MAX_CHANNELS) ? PS_AW'(MAX_CHANNELS)
                                                               : PS_AW'(channel_count_reg);
    assign wf_clamp = (int'(window_first) > MAX_CHANNELS) ? PS_AW'(MAX_CHANNELS)
                                                          : PS_AW'(window_first);
    assign we_clamp = (int'(window_end) > MAX_CHANNELS) ? PS_AW'(MAX_CHANNELS)
                                                        : PS_AW'(window_end);

    assign ch_freq  = ch_rd_reg[CH_W-1 -: 20];
    assign ch_power = ch_rd_reg[CH_W-21 -: 32];
    assign ch_wf    = ch_rd_reg[2*PS_AW-1 -: PS_AW];
    assign ch_wend  = ch_rd_reg[PS_AW-1:0];

    // Prefix entry zero is never written and always reads as zero.
    assign ps_rd    = ps_zero_reg ? 41'd0 : ps_rd_reg;
    assign ps_sum   = {1'b0, ps_rd} + {10'd0, pow_reg};
    assign win_sum  = (ps_rd > pf_reg) ? (ps_rd - pf_reg) : 41'd0;

    assign sq       = {31'd0, mant_reg} * {31'd0, mant_reg};
    assign sq_sh    = sq[61:30];
    assign db_full  = {18'd0, 6'd40 - sh_reg, frac_reg} * {22'd0, DB_PER_OCTAVE} + 40'd32768;
    assign lv_calc  = $signed({2'b00, db_full[39:16]}) - LEVEL_OFFSET;
    assign mag      = lv_reg[25] ? 25'(-lv_reg) : 25'(lv_reg);
    assign m2_full  = {25'd0, pl_reg} * {16'd0, mag} + 41'd2048;
    assign sp       = lv_reg[25] ? ($signed({7'd0, pu_reg}) + $signed({2'd0, mag2_reg}))
                                 : ($signed({7'd0, pu_reg}) - $signed({2'd0, mag2_reg}));
    assign rem2     = {rem_reg, quot_reg[QUOT_W-1]};
    assign idx_full = {18'd0, quot_reg} * 40'(IDX_MUL) + 40'(1 << 24);
    assign rom_addr = ((idx_full >> 25) > 40'(ROEX_TABLE_SIZE - 1))
                      ? RM_AW'(ROEX_TABLE_SIZE - 1) : RM_AW'(idx_full >> 25);
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, prod_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == OP_LOAD_CHANNEL && idx_ok_channel)
                begin
                    state_next = S_LOAD_WR;
                end
                else if (accept && operation == OP_COMPUTE && idx_ok_filter)
                begin
                    state_next = S_FILT_WAIT;
                end
            end
            S_LOAD_WR:   state_next = S_IDLE;
            S_FILT_WAIT:
            begin
                if (filt_rd_reg[FL_W-1 -: 20] == 20'd0 || n_clamp == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CH_RD;
                end
            end
            S_CH_RD:     state_next = S_CH_TEST;
            S_CH_TEST:
            begin
                if ({2'd0, ch_freq} > 22'(fc_reg) * 22'd3)
                begin
                    state_next = S_DONE;
                end
                else if (ch_freq < fc_reg)
                begin
                    state_next = S_PF_FIRST;
                end
                else
                begin
                    state_next = S_PROD;
                end
            end
            S_PF_FIRST:  state_next = S_PF_END;
            S_PF_END:    state_next = (win_sum == 41'd0) ? S_MAG : S_NORM;
            S_NORM:      state_next = norm_reg[40] ? S_LOG : S_NORM;
            S_LOG:       state_next = (step_reg == 4'd15) ? S_DB : S_LOG;
            S_DB:        state_next = S_MAG;
            S_MAG:       state_next = S_SLOPE;
            S_SLOPE:     state_next = S_PROD;
            S_PROD:      state_next = S_DIV_CHK;
            S_DIV_CHK:
            begin
                if (num_reg >= {7'd0, fc_reg, 22'd0})
                begin
                    state_next = S_IDX;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:       state_next = (div_cnt_reg == 5'(QUOT_W - 1)) ? S_IDX : S_DIV;
            S_IDX:       state_next = S_ACC;
            S_ACC:       state_next = S_ADD;
            S_ADD:       state_next = (j_reg + 1'b1 == n_clamp) ? S_DONE : S_CH_RD;
            S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Memory control.
    always_comb
    begin
        filt_we    = 1'b0;
        filt_waddr = FL_AW'(item_index);
        filt_wdata = {frequency, upper_slope, lower_slope};
        filt_raddr = FL_AW'(item_index);
        ch_we      = 1'b0;
        ch_waddr   = CH_AW'(ix_reg);
        ch_wdata   = {freq_reg, pow_reg, wf_reg, we_reg};
        ch_raddr   = CH_AW'(j_reg);
        ps_we      = 1'b0;
        ps_waddr   = PS_AW'(ix_reg) + 1'b1;
        ps_wdata   = ps_sum[41] ? PREFIX_MAX : ps_sum[40:0];
        ps_raddr   = '0;
        case (state_reg)
            S_IDLE:
            begin
                filt_we  = accept && operation == OP_LOAD_FILTER && idx_ok_filter;
                ps_raddr = PS_AW'(item_index);
            end
            S_LOAD_WR:
            begin
                ch_we = 1'b1;
                ps_we = 1'b1;
            end
            S_CH_TEST:  ps_raddr = ch_wf;
            S_PF_FIRST: ps_raddr = we_reg;
            default:    ps_raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (filt_we)
        begin
            filt_mem[filt_waddr] <= filt_wdata;
        end
        filt_rd_reg <= filt_mem[filt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            ch_mem[ch_waddr] <= ch_wdata;
        end
        ch_rd_reg <= ch_mem[ch_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ps_we)
        begin
            ps_mem[ps_waddr] <= ps_wdata;
        end
        ps_rd_reg   <= ps_mem[ps_raddr];
        ps_zero_reg <= (ps_raddr == '0);
    end

    always_ff @(posedge clk)
    begin
        rom_rd_reg <= ROEX_ROM[rom_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            channel_count_reg <= CHANNEL_COUNT_RESET;
            out_valid_reg     <= 1'b0;
            j_reg             <= '0;
            step_reg          <= '0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                channel_count_reg <= cfg_data;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_FILT_WAIT: j_reg <= '0;
                S_ADD:       j_reg <= j_reg + 1'b1;
                default:     j_reg <= j_reg;
            endcase
            case (state_reg)
                S_LOG:   step_reg <= step_reg + 1'b1;
                default: step_reg <= '0;
            endcase
            case (state_reg)
                S_DIV:   div_cnt_reg <= div_cnt_reg + 1'b1;
                default: div_cnt_reg <= '0;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ix_reg   <= item_index;
                freq_reg <= frequency;
                pow_reg  <= channel_power;
                wf_reg   <= wf_clamp;
                we_reg   <= we_clamp;
            end
            S_FILT_WAIT:
            begin
                fc_reg  <= filt_rd_reg[FL_W-1 -: 20];
                pu_reg  <= {filt_rd_reg[31:16], 8'd0};
                pl_reg  <= filt_rd_reg[15:0];
                acc_reg <= '0;
            end
            S_CH_TEST:
            begin
                pow_reg <= ch_power;
                we_reg  <= ch_wend;
                if (ch_freq < fc_reg)
                begin
                    dm_reg <= fc_reg - ch_freq;
                end
                else
                begin
                    dm_reg <= ch_freq - fc_reg;
                    p_reg  <= {5'd0, pu_reg};
                end
            end
            S_PF_FIRST: pf_reg <= ps_rd;
            S_PF_END:
            begin
                norm_reg <= win_sum;
                sh_reg   <= '0;
                lv_reg   <= LEVEL_EMPTY;
            end
            S_NORM:
            begin
                if (norm_reg[40:33] == 8'd0)
                begin
                    norm_reg <= {norm_reg[32:0], 8'd0};
                    sh_reg   <= sh_reg + 6'd8;
                end
                else if (!norm_reg[40])
                begin
                    norm_reg <= {norm_reg[39:0], 1'b0};
                    sh_reg   <= sh_reg + 6'd1;
                end
                mant_reg <= norm_reg[40:10];
            end
            S_LOG:
            begin
                mant_reg <= sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
                frac_reg <= {frac_reg[14:0], sq_sh[31]};
            end
            S_DB:    lv_reg   <= lv_calc;
            S_MAG:   mag2_reg <= m2_full[40:12];
            S_SLOPE: p_reg    <= (sp < $signed({2'd0, SLOPE_MIN})) ? SLOPE_MIN : sp[28:0];
            S_PROD:  num_reg  <= {20'd0, p_reg} * {29'd0, dm_reg};
            S_DIV_CHK:
            begin
                // The high part is below fc whenever the divider runs.
                rem_reg  <= num_reg[41:22];
                quot_reg <= (num_reg >= {7'd0, fc_reg, 22'd0}) ? {QUOT_W{1'b1}}
                                                              : num_reg[QUOT_W-1:0];
            end
            S_DIV:
            begin
                if (rem2 >= {1'b0, fc_reg})
                begin
                    rem_reg  <= 20'(rem2 - {1'b0, fc_reg});
                    quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem2[19:0];
                    quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
                end
            end
            S_ACC:   prod_reg <= {32'd0, rom_rd_reg} * {16'd0, pow_reg};
            S_ADD:   acc_reg  <= acc_sum[48] ? {48{1'b1}} : acc_sum[47:0];
            S_DONE:
            begin
                if (out_free)
                begin
                    filter_number_reg <= ix_reg;
                    excitation_reg    <= acc_reg;
                end
            end
            default:
            begin
                ix_reg <= ix_reg;
            end
        endcase
        if (state_reg == S_NORM && norm_reg[40])
        begin
            frac_reg <= '0;
        end
    end

    // The squaring loop keeps its mantissa normalized to [1, 2).
    a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOG) |-> mant_reg[30])
        else $error("log2 mantissa lost normalization");

    // The restoring divider remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < fc_reg))
        else $error("divider remainder out of range");

    // The channel walk never reads past the configured channel count.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CH_RD) |-> (j_reg < n_clamp))
        else $error("channel walk past channel count");

    // A result is presented only after a compute item finishes.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result without a finished compute item");

endmodule

// ----- tb/tb_roex_excitation_pattern_unit.sv -----
// Self-checking testbench for roex_excitation_pattern_unit: loads filters and
// spectrum channels, runs excitation computes and checks every result against
// a bit-true predictor. Depends on roex_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_roex_excitation_pattern_unit;
    import roex_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NCH = 512;
    localparam int NFI = 512;
    localparam int ROM_SIZE = 1024;
    localparam int IDLE_LIMIT = 250000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [8:0]  number;
        logic [47:0] value;
    } excitation_t;

    class excitation_scoreboard;
        logic [19:0] filt_centre[NFI];
        logic [15:0] filt_upper[NFI];
        logic [15:0] filt_lower[NFI];
        logic [19:0] chan_freq[NCH];
        logic [31:0] chan_power[NCH];
        logic [9:0]  win_first[NCH];
        logic [9:0]  win_end[NCH];
        longint unsigned prefix[NCH + 1];
        logic [15:0] roex[ROM_SIZE];
        logic [9:0]  walk_count;
        excitation_t pending_q[$];
        int errors;

        function new();
            longint unsigned den, t, e, r, r40, v40, q;
            prefix[0] = 0;
            walk_count = CHANNEL_COUNT_RESET;
            errors = 0;
            den = 25 * ROM_SIZE;
            t = 64'd1 << 62;
            e = 64'd1 << 62;
            r = 64'd1 << 62;
            for (longint unsigned k = 1; k < 64 && t != 0; k++)
            begin
                t = (t / (den * k)) * 512;
                if (k[0]) e = e - t;
                else e = e + t;
            end
            for (int i = 0; i < ROM_SIZE; i++)
            begin
                if (i > 0) r = q62_product(r, e);
                r40 = r >> 22;
                v40 = r40 + (r40 * longint'(i) * 512) / den;
                q = (v40 + (64'd1 << 23)) >> 24;
                roex[i] = (q > 65535) ? 16'hFFFF : q[15:0];
            end
        endfunction

        function longint unsigned q62_product(longint unsigned a, longint unsigned b);
            logic [127:0] full;
            full = {64'd0, a} * {64'd0, b};
            return full[125:62];
        endfunction

        // Window level in signed Q16 dB with the 51 dB offset removed.
        function longint level_db(longint unsigned s);
            longint unsigned mant, l2, db;
            int ex;
            if (s == 0) return -longint'(151) * 65536;
            ex = 0;
            while (ex < 63 && (s >> (ex + 1)) != 0) ex++;
            mant = (ex <= 30) ? (s << (30 - ex)) : (s >> (ex - 30));
            l2 = longint'(ex) << 16;
            for (int b = 0; b < 16; b++)
            begin
                mant = (mant * mant) >> 30;
                if (mant >= (64'd1 << 31))
                begin
                    mant = mant >> 1;
                    l2 = l2 | (64'd1 << (15 - b));
                end
            end
            db = (l2 * 197283 + 32768) >> 16;
            return longint'(db) - longint'(51) * 65536;
        endfunction

        function logic [47:0] excitation_of(int fi);
            longint unsigned fc, pu, pl, acc, cf, p, dm, pg, idx, mag, pf, pe, ws;
            longint lv, sp;
            int n;
            fc = filt_centre[fi];
            pu = longint'(filt_upper[fi]) << 8;
            pl = filt_lower[fi];
            acc = 0;
            n = (walk_count > NCH) ? NCH : walk_count;
            if (fc == 0) return 48'd0;
            for (int j = 0; j < n; j++)
            begin
                cf = chan_freq[j];
                if (cf > 3 * fc) break;
                if (cf < fc)
                begin
                    pf = prefix[win_first[j]];
                    pe = prefix[win_end[j]];
                    ws = (pe > pf) ? pe - pf : 0;
                    lv = level_db(ws);
                    mag = (lv < 0) ? longint'(-lv) : longint'(lv);
                    mag = (pl * mag + 2048) >> 12;
                    sp = (lv >= 0) ? longint'(pu) - longint'(mag) : longint'(pu) + longint'(mag);
                    p = (sp < 6554) ? 6554 : sp;
                    dm = fc - cf;
                end
                else
                begin
                    p = pu;
                    dm = cf - fc;
                end
                pg = (p * dm) / fc;
                idx = (pg * ROM_SIZE * 25 + (64'd1 << 24)) >> 25;
                if (idx > ROM_SIZE - 1) idx = ROM_SIZE - 1;
                acc += longint'(roex[idx]) * longint'(chan_power[j]);
            end
            return (acc > 48'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : acc[47:0];
        endfunction

        function void note_item(logic [1:0] op, logic [8:0] ix, logic [19:0] fq,
                                logic [31:0] pw, logic [8:0] wf, logic [9:0] we,
                                logic [15:0] us, logic [15:0] ls);
            longint unsigned s;
            excitation_t res;
            if (op == OP_LOAD_FILTER)
            begin
                filt_centre[ix] = fq;
                filt_upper[ix] = us;
                filt_lower[ix] = ls;
            end
            else if (op == OP_LOAD_CHANNEL)
            begin
                s = prefix[ix] + pw;
                chan_freq[ix] = fq;
                chan_power[ix] = pw;
                win_first[ix] = wf;
                win_end[ix] = (we > NCH) ? 10'(NCH) : we;
                prefix[ix + 1] = (s > PREFIX_MAX) ? PREFIX_MAX : s;
            end
            else if (op == OP_COMPUTE)
            begin
                res.number = ix;
                res.value = excitation_of(ix);
                pending_q.push_back(res);
            end
        endfunction

        function void check_result(logic [8:0] num, logic [47:0] exc);
            excitation_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result filter %0d excitation %0h", $time, num, exc);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (num !== want.number)
            begin
                $display("%0t: filter_number expected %0d actual %0d", $time, want.number, num);
                errors++;
            end
            if (exc !== want.value)
            begin
                $display("%0t: excitation expected %0h actual %0h", $time, want.value, exc);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [8:0]  item_index = '0;
    logic [19:0] frequency = '0;
    logic [31:0] channel_power = '0;
    logic [8:0]  window_first = '0;
    logic [9:0]  window_end = '0;
    logic [15:0] upper_slope = '0;
    logic [15:0] lower_slope = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [8:0]  filter_number;
    logic [47:0] excitation;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;

    excitation_scoreboard sb = new();
    bit filter_loaded[NFI];
    int loaded_filters[$];
    bit calm = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    roex_excitation_pattern_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .item_index(item_index), .frequency(frequency),
        .channel_power(channel_power), .window_first(window_first),
        .window_end(window_end), .upper_slope(upper_slope), .lower_slope(lower_slope),
        .out_valid(out_valid), .out_stall(out_stall),
        .filter_number(filter_number), .excitation(excitation),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: check on acceptance, then choose the next stall level.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(filter_number, excitation);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap();
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [8:0] ix, logic [19:0] fq,
                             logic [31:0] pw, logic [8:0] wf, logic [9:0] we,
                             logic [15:0] us, logic [15:0] ls);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        item_index <= ix;
        frequency <= fq;
        channel_power <= pw;
        window_first <= wf;
        window_end <= we;
        upper_slope <= us;
        lower_slope <= ls;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_item(op, ix, fq, pw, wf, we, us, ls);
        if (op == OP_LOAD_FILTER && !filter_loaded[ix])
        begin
            filter_loaded[ix] = 1'b1;
            loaded_filters.push_back(ix);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_q.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_channel_count(logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.walk_count = value;
        cfg_valid <= 1'b0;
    endtask

    function logic [31:0] pick_power();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'hFFFF_FFFF;
        if (r < 5) return $urandom_range(1, 1000);
        return $urandom();
    endfunction

    task automatic load_channel(int j);
        logic [19:0] fq;
        int f, e;
        fq = 20'(j * 2000 + $urandom_range(0, 1999));
        if ($urandom_range(0, 6) == 0) fq = 20'($urandom());
        f = j - $urandom_range(0, 8);
        e = j + 1 + $urandom_range(0, 8);
        if (f < 0) f = 0;
        if (e > NCH) e = NCH;
        if ($urandom_range(0, 9) == 0)
        begin
            // Random bounds, often an empty or inverted window.
            f = $urandom_range(0, NCH - 1);
            e = $urandom_range(0, NCH);
        end
        send_item(OP_LOAD_CHANNEL, 9'(j), fq, pick_power(), 9'(f), 10'(e),
                  16'($urandom()), 16'($urandom()));
    endtask

    task automatic random_item();
        int r;
        logic [19:0] fc;
        r = $urandom_range(0, 99);
        if (r < 18 || loaded_filters.size() == 0)
        begin
            fc = 20'($urandom_range(1, 300000));
            if ($urandom_range(0, 9) == 0) fc = 20'($urandom());
            if ($urandom_range(0, 29) == 0) fc = '0;
            send_item(OP_LOAD_FILTER, 9'($urandom_range(0, NFI - 1)), fc, $urandom(),
                      9'($urandom()), 10'($urandom()), 16'($urandom()), 16'($urandom()));
        end
        else if (r < 55)
            load_channel($urandom_range(0, NCH - 1));
        else if (r < 95)
            send_item(OP_COMPUTE,
                      9'(loaded_filters[$urandom_range(0, loaded_filters.size() - 1)]),
                      20'($urandom()), $urandom(), 9'($urandom()), 10'($urandom()),
                      16'($urandom()), 16'($urandom()));
        else
            send_item(OP_UNUSED, 9'($urandom()), 20'($urandom()), $urandom(),
                      9'($urandom()), 10'($urandom()), 16'($urandom()), 16'($urandom()));
    endtask

    initial
    begin
        int cnt;
        int n_items;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every channel once so that no walk or window reads an empty entry.
        for (int j = 0; j < NCH; j++)
            load_channel(j);

        // Directed: slope and center extremes, zero center, unused operation.
        send_item(OP_LOAD_FILTER, 9'd0, 20'd16000, 32'd0, 9'd0, 10'd0, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD_FILTER, 9'd511, 20'hFFFFF, 32'd0, 9'd0, 10'd0, 16'd0, 16'd0);
        send_item(OP_LOAD_FILTER, 9'd1, 20'd0, 32'd0, 9'd0, 10'd0, 16'h0100, 16'h1000);
        send_item(OP_LOAD_FILTER, 9'd2, 20'd1, 32'd0, 9'd0, 10'd0, 16'h8000, 16'h8000);
        send_item(OP_LOAD_FILTER, 9'd3, 20'd400000, 32'd0, 9'd0, 10'd0, 16'h0400, 16'h0800);
        send_item(OP_LOAD_CHANNEL, 9'd5, 20'd10000, 32'hFFFF_FFFF, 9'd7, 10'd7, 16'd0, 16'd0);
        send_item(OP_LOAD_CHANNEL, 9'd6, 20'd12000, 32'd0, 9'd9, 10'd2, 16'd0, 16'd0);
        send_item(OP_LOAD_CHANNEL, 9'd7, 20'd14000, 32'd1, 9'd0, 10'd512, 16'd0, 16'd0);
        send_item(OP_UNUSED, 9'h1FF, 20'hFFFFF, 32'hFFFF_FFFF, 9'h1FF, 10'h3FF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 4; k++)
            send_item(OP_COMPUTE, 9'(k), '0, '0, '0, '0, '0, '0);
        send_item(OP_COMPUTE, 9'd511, 20'hFFFFF, 32'hFFFF_FFFF, 9'h1FF, 10'h3FF, 16'hFFFF, 16'hFFFF);
        wait_drained();

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 0) cnt = 1;
            else if (ph == 4) cnt = NCH;
            else cnt = $urandom_range(2, 24);
            write_channel_count(10'(cnt));
            calm = (ph % 3 == 1);
            n_items = (cnt == NCH) ? 20 : 55;
            for (int i = 0; i < n_items; i++)
                random_item();
            wait_drained();
        end
        calm = 1'b0;

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
